[src/strmq_pkg.sv]
package strmq_pkg;

  localparam int MAX_ELEMENTS  = 1024;
  localparam int ELEMENT_WIDTH = 8;
  localparam int IDX_W         = $clog2(MAX_ELEMENTS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int LEVEL_COUNT   = IDX_W + 1;
  localparam int LVL_W         = $clog2(LEVEL_COUNT);
  localparam int ADDR_W        = LVL_W + IDX_W;
  localparam int DEPTH         = LEVEL_COUNT * MAX_ELEMENTS;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  // query decode handed from the address unit to the top level
  typedef struct packed {
    logic  err;
    addr_t addr_a;
    addr_t addr_b;
  } qaddr_t;

  // flat store address of entry idx on level lvl
  function automatic addr_t mk_addr(logic [LVL_W-1:0] lvl, logic [IDX_W-1:0] idx);
    return {lvl, idx};
  endfunction

  function automatic elem_t min2(elem_t a, elem_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

[src/sparse_table_range_min.sv]
// Range-minimum sparse table over up to 1024 unsigned 8-bit elements.
// A request is taken when start_i is high and busy_o is low. A load never
// blocks the next request unless it starts the build. A query reads two
// blocks of the level store in the cycle it is taken; the result appears
// on minimum_o/error_o with valid_o high for exactly one cycle on the next
// cycle, during which busy_o is high, so the next request waits for it.
// The receiver cannot stall results. A load marked last starts the build
// once two or more elements are held: every level i from 1 up with 2^i not
// above the count is swept on the store's read ports, busy_o high
// throughout. The store needs no clearing pass after reset.
module sparse_table_range_min (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  strmq_pkg::elem_t            value_i,
  input  logic                        last_i,
  input  logic [strmq_pkg::IDX_W-1:0] left_i,
  input  logic [strmq_pkg::IDX_W-1:0] right_i,
  output logic                        valid_o,
  output strmq_pkg::elem_t            minimum_o,
  output logic                        error_o
);
  import strmq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_QRES  = 2'd1;
  localparam logic [1:0] S_BUILD = 2'd2;
  localparam logic [1:0] S_BNEXT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             built_q, built_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic             qerr_q, qerr_d;
  logic             wb_valid_q;
  addr_t            wb_addr_q;

  logic             accept;
  logic [CNT_W-1:0] base_count;
  logic             load_wr;
  logic [CNT_W-1:0] new_count;
  logic [IDX_W-1:0] half;
  logic [CNT_W-1:0] last_j;
  logic [LVL_W-1:0] lvl_prev;
  logic [LVL_W:0]   lvl_next;
  logic [CNT_W:0]   next_span;

  qaddr_t           qaddr;
  elem_t            rdata_a, rdata_b;
  elem_t            rmin;
  logic             mem_we;
  addr_t            mem_waddr;
  elem_t            mem_wdata;
  addr_t            raddr_a, raddr_b;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // query range decode
  strmq_qaddr u_qaddr (
    .left_i  (left_i),
    .right_i (right_i),
    .count_i (count_q),
    .built_i (built_q),
    .qaddr_o (qaddr)
  );

  // load bookkeeping: a load after a build starts a new sequence
  assign base_count = built_q ? '0 : count_q;
  assign load_wr    = accept && (kind_i == KIND_LOAD) &&
                      (base_count < CNT_W'(MAX_ELEMENTS));
  assign new_count  = load_wr ? base_count + CNT_W'(1) : base_count;

  // build sweep geometry
  assign lvl_prev  = lvl_q - LVL_W'(1);
  assign half      = IDX_W'(CNT_W'(1) << lvl_prev);
  assign last_j    = count_q - (CNT_W'(1) << lvl_q);
  assign lvl_next  = {1'b0, lvl_q} + (LVL_W+1)'(1);
  assign next_span = (CNT_W+1)'(1) << lvl_next;

  // control
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    built_d = built_q;
    lvl_d   = lvl_q;
    j_d     = j_q;
    qerr_d  = qerr_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_QUERY) begin
            qerr_d  = qaddr.err;
            state_d = S_QRES;
          end else begin
            count_d = new_count;
            built_d = 1'b0;
            if (last_i) begin
              if (new_count >= CNT_W'(2)) begin
                lvl_d   = LVL_W'(1);
                j_d     = '0;
                state_d = S_BUILD;
              end else begin
                built_d = 1'b1;
              end
            end
          end
        end
      end
      S_QRES: begin
        state_d = S_IDLE;
      end
      S_BUILD: begin
        if ({1'b0, j_q} == last_j) begin
          state_d = S_BNEXT;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_BNEXT: begin
        if ((lvl_next < (LVL_W+1)'(LEVEL_COUNT)) && (next_span <= {1'b0, count_q})) begin
          lvl_d   = LVL_W'(lvl_next);
          j_d     = '0;
          state_d = S_BUILD;
        end else begin
          built_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      built_q    <= 1'b0;
      lvl_q      <= '0;
      j_q        <= '0;
      qerr_q     <= 1'b0;
      wb_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      built_q    <= built_d;
      lvl_q      <= lvl_d;
      j_q        <= j_d;
      qerr_q     <= qerr_d;
      wb_valid_q <= (state_q == S_BUILD);
    end
  end

  // build writeback target, registered so it is written in the cycle after its reads
  always_ff @(posedge clk_i) begin
    wb_addr_q <= mk_addr(lvl_q, j_q);
  end

  // store port steering
  assign rmin      = min2(rdata_a, rdata_b);
  assign mem_we    = load_wr || wb_valid_q;
  assign mem_waddr = wb_valid_q ? wb_addr_q : mk_addr('0, base_count[IDX_W-1:0]);
  assign mem_wdata = wb_valid_q ? rmin : value_i;
  assign raddr_a   = (state_q == S_BUILD) ? mk_addr(lvl_prev, j_q) : qaddr.addr_a;
  assign raddr_b   = (state_q == S_BUILD) ? mk_addr(lvl_prev, j_q + half) : qaddr.addr_b;

  strmq_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // result
  assign valid_o   = (state_q == S_QRES);
  assign error_o   = qerr_q;
  assign minimum_o = qerr_q ? '0 : rmin;

`ifndef SYNTHESIS
  a_query_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_QUERY)) |=> valid_o)
    else $error("query request gave no result");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_built_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> (count_q != '0))
    else $error("table built with no elements");

  a_wb_in_build : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q |-> ((state_q == S_BUILD) || (state_q == S_BNEXT)))
    else $error("build writeback outside build");
`endif

endmodule

[src/strmq_mem.sv]
module strmq_mem (
  input  logic           clk_i,
  input  logic           we_i,
  input  strmq_pkg::addr_t waddr_i,
  input  strmq_pkg::elem_t wdata_i,
  input  strmq_pkg::addr_t raddr_a_i,
  input  strmq_pkg::addr_t raddr_b_i,
  output strmq_pkg::elem_t rdata_a_o,
  output strmq_pkg::elem_t rdata_b_o
);
  import strmq_pkg::*;

  elem_t mem_q [DEPTH];
  elem_t rdata_a_q;
  elem_t rdata_b_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/strmq_qaddr.sv]
module strmq_qaddr (
  input  logic [strmq_pkg::IDX_W-1:0] left_i,
  input  logic [strmq_pkg::IDX_W-1:0] right_i,
  input  logic [strmq_pkg::CNT_W-1:0] count_i,
  input  logic                        built_i,
  output strmq_pkg::qaddr_t           qaddr_o
);
  import strmq_pkg::*;

  logic [CNT_W-1:0] len;
  logic [LVL_W-1:0] k;
  logic [CNT_W-1:0] span;
  logic [IDX_W-1:0] idx_b;

  // range check
  assign qaddr_o.err = !built_i || (left_i > right_i) ||
                       ({1'b0, right_i} >= count_i);

  // range length and its floor log2
  assign len = {1'b0, right_i} - {1'b0, left_i} + CNT_W'(1);

  always_comb begin
    k = '0;
    for (int b = 1; b < CNT_W; b++) begin
      if (len[b]) begin
        k = LVL_W'(b);
      end
    end
  end

  // second block ends at right
  assign span  = CNT_W'(1) << k;
  assign idx_b = IDX_W'({1'b0, right_i} - span + CNT_W'(1));

  assign qaddr_o.addr_a = mk_addr(k, left_i);
  assign qaddr_o.addr_b = mk_addr(k, idx_b);

endmodule

[dv/sparse_table_range_min_tb.sv]
`timescale 1ns / 1ps

module testbench;
  import strmq_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 800000;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASE_ITEMS  = 200;

  typedef struct {
    logic             kind;
    elem_t            value;
    logic             last;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } request_t;

  typedef struct {
    elem_t minimum;
    logic  error;
  } range_result_t;

  // dut ports; the inputs are known from time zero
  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start_i = 1'b0;
  logic             kind_i  = KIND_LOAD;
  elem_t            value_i = '0;
  logic             last_i  = 1'b0;
  logic [IDX_W-1:0] left_i  = '0;
  logic [IDX_W-1:0] right_i = '0;
  logic             busy_o;
  logic             valid_o;
  elem_t            minimum_o;
  logic             error_o;

  // stimulus and expectation stores
  request_t      pending_requests[$];
  range_result_t due_minimums[$];

  // shadow copy of the table contents
  elem_t shadow_elems[MAX_ELEMENTS];
  int    shadow_count = 0;
  bit    shadow_built = 1'b0;

  int mismatches     = 0;
  int accepted_count = 0;
  int load_count     = 0;
  int query_count    = 0;
  int refused_count  = 0;
  int build_count    = 0;
  int dropped_count  = 0;

  sparse_table_range_min dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .kind_i    (kind_i),
    .value_i   (value_i),
    .last_i    (last_i),
    .left_i    (left_i),
    .right_i   (right_i),
    .valid_o   (valid_o),
    .minimum_o (minimum_o),
    .error_o   (error_o)
  );

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // update the shadow table for one accepted request, queue its result
  task automatic predict_range_min(input request_t r);
    range_result_t res;
    int            i;
    if (r.kind == KIND_LOAD) begin
      load_count++;
      // a load after a build opens a new sequence
      if (shadow_built) begin
        shadow_built = 1'b0;
        shadow_count = 0;
      end
      if (shadow_count < MAX_ELEMENTS) begin
        shadow_elems[shadow_count] = r.value;
        shadow_count++;
      end else begin
        dropped_count++;
      end
      if (r.last) begin
        shadow_built = 1'b1;
        build_count++;
      end
    end else begin
      query_count++;
      res.minimum = '0;
      res.error   = !shadow_built || (r.left > r.right) || (r.right >= shadow_count);
      if (res.error) begin
        refused_count++;
      end else begin
        res.minimum = '1;
        for (i = int'(r.left); i <= int'(r.right); i++) begin
          if (shadow_elems[i] < res.minimum) res.minimum = shadow_elems[i];
        end
      end
      due_minimums.push_back(res);
    end
  endtask

  task automatic queue_load(input int value, input logic last_flag);
    request_t r;
    r.kind  = KIND_LOAD;
    r.value = elem_t'(value);
    r.last  = last_flag;
    r.left  = IDX_W'($urandom);
    r.right = IDX_W'($urandom);
    pending_requests.push_back(r);
  endtask

  task automatic queue_query(input int left, input int right);
    request_t r;
    r.kind  = KIND_QUERY;
    r.value = elem_t'($urandom);
    r.last  = 1'($urandom);
    r.left  = IDX_W'(left);
    r.right = IDX_W'(right);
    pending_requests.push_back(r);
  endtask

  // query inside [0, n-1]
  task automatic queue_valid_query(input int n);
    int lo;
    lo = $urandom_range(n - 1, 0);
    queue_query(lo, $urandom_range(n - 1, lo));
  endtask

  // sender idle rate per phase: none, heavy, light
  function automatic int sender_idle_pct();
    case ((accepted_count / PHASE_ITEMS) % 3)
      0:       return 0;
      1:       return 60;
      default: return 19;
    endcase
  endfunction

  // driver: holds a request until taken, then picks the next one
  always @(posedge clk_i) begin : driver
    request_t next_req;
    logic     take_next;
    request_t in_flight;
    if (rst_ni) begin
      take_next = !start_i;
      if (start_i && !busy_o) begin
        predict_range_min(in_flight);
        accepted_count++;
        take_next = 1'b1;
      end
      if (take_next) begin
        if (pending_requests.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
          next_req  = pending_requests.pop_front();
          in_flight = next_req;
          start_i   <= 1'b1;
          kind_i    <= next_req.kind;
          value_i   <= next_req.value;
          last_i    <= next_req.last;
          left_i    <= next_req.left;
          right_i   <= next_req.right;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin : monitor
    range_result_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      if (due_minimums.size() == 0) begin
        report_mismatch($sformatf("result min=%0d err=%0b with none due", minimum_o, error_o));
      end else begin
        want = due_minimums.pop_front();
        if (minimum_o !== want.minimum)
          report_mismatch($sformatf("minimum %0d, want %0d", minimum_o, want.minimum));
        if (error_o !== want.error)
          report_mismatch($sformatf("error %0b, want %0b", error_o, want.error));
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int  n;
    int  q;
    int  pick;
    int  random_items;
    bit  big_done;
    random_items = 0;
    big_done     = 1'b0;

    // directed: queries before any build
    queue_query(0, 0);
    queue_query(1023, 1023);
    // single element table
    queue_load(8'd255, 1'b1);
    queue_query(0, 0);
    queue_query(0, 1);
    // five elements with extreme values
    queue_load(8'd0, 1'b0);
    queue_load(8'd255, 1'b0);
    queue_load(8'd128, 1'b0);
    queue_load(8'd1, 1'b0);
    queue_load(8'd254, 1'b1);
    queue_query(0, 4);
    queue_query(1, 4);
    queue_query(4, 4);
    queue_query(3, 1);
    queue_query(2, 5);
    queue_query(1023, 0);
    queue_query(1, 2);
    // new sequence clears the table, query while loading
    queue_load(8'd7, 1'b0);
    queue_query(0, 0);
    queue_load(8'd9, 1'b1);
    queue_query(0, 1);

    // random: mostly well-formed load sequences followed by queries
    while (random_items < RANDOM_ITEMS) begin
      // one full table with loads past capacity, done once
      if (!big_done && random_items >= RANDOM_ITEMS / 4) begin
        big_done = 1'b1;
        for (int i = 0; i < MAX_ELEMENTS + 3; i++)
          queue_load($urandom_range(255, 0), i == MAX_ELEMENTS + 2);
        queue_query(0, 1023);
        queue_query(1023, 1023);
        queue_query(512, 1023);
        for (int i = 0; i < 30; i++) queue_valid_query(MAX_ELEMENTS);
        random_items += MAX_ELEMENTS + 3 + 33;
      end
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        n = ($urandom_range(99, 0) < 5) ? $urandom_range(300, 41) : $urandom_range(40, 1);
        for (int i = 0; i < n; i++) queue_load($urandom_range(255, 0), i == n - 1);
        q = $urandom_range(12, 1);
        for (int i = 0; i < q; i++) begin
          if ($urandom_range(99, 0) < 85) queue_valid_query(n);
          else queue_query($urandom, $urandom);
        end
        random_items += n + q;
      end else if (pick < 90) begin
        q = $urandom_range(4, 1);
        for (int i = 0; i < q; i++) queue_query($urandom, $urandom);
        random_items += q;
      end else begin
        // unfinished sequence, queried while loading
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) queue_load($urandom_range(255, 0), 1'b0);
        queue_query(0, 0);
        queue_query($urandom, $urandom);
        random_items += n + 2;
      end
    end

    // wait for the last request to be taken and all results to drain
    wait (pending_requests.size() == 0);
    @(posedge clk_i);
    while (start_i) @(posedge clk_i);
    while (due_minimums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads (%0d dropped past capacity), %0d builds",
             load_count, dropped_count, build_count);
    $display("covered %0d queries, %0d of them refused", query_count, refused_count);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // reset release
  initial begin : reset_gen
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout at %0t ns", $time);
    $display("FAILURE");
    $finish;
  end

endmodule
